@@ rtl/lat_pkg.sv @@
package lat_pkg;

  // Node store geometry
  localparam int NODES   = 1024;
  localparam int NODE_AW = (NODES > 1) ? $clog2(NODES) : 1;

  // Field widths
  localparam int NODE_W  = 10;
  localparam int SF_W    = 4;
  localparam int PL_W    = 8;
  localparam int AIR_W   = 26;
  localparam int NSYM_W  = 12;
  localparam int TOTAL_W = 40;
  localparam int COUNT_W = 32;

  // Divider geometry: dividend holds num + den - 1, divisor is 4 * (SF - 2 * DE)
  localparam int DVD_W     = 12;
  localparam int DSR_W     = 6;
  localparam int DIV_STEPS = DVD_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

  // Airtime datapath
  localparam int BASE_W  = 20;
  localparam int SHIFT_W = 4;
  localparam int WIDE_W  = BASE_W + 13;

  localparam logic [AIR_W-1:0]   AIR_MAX   = {AIR_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Spreading factor and coding rate limits
  localparam logic [SF_W-1:0] SF_MIN = 4'd6;
  localparam logic [SF_W-1:0] SF_MAX = 4'd12;
  localparam logic [SF_W-1:0] SF_LDRO = 4'd11;
  localparam logic [2:0]      CR_MIN = 3'd1;
  localparam logic [2:0]      CR_MAX = 3'd4;
  localparam logic [1:0]      BW_125 = 2'd0;
  localparam logic [1:0]      BW_500 = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_BANDWIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODING    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMPLICIT  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SYM,
    ST_AIR,
    ST_ACC
  } lat_state_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DSR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DVD_W-1:0]  quotient;
  } div_rsp_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [COUNT_W-1:0] count;
  } node_rec_t;

  typedef struct packed {
    logic               rd_en;
    logic               wr_en;
    logic [NODE_AW-1:0] addr;
    node_rec_t          wr_data;
  } store_req_t;

endpackage

@@ rtl/lat_div.sv @@
module lat_div
  import lat_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [DSR_W-1:0]  rem_r, rem_nxt;
  logic [DSR_W-1:0]  dsr_r, dsr_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DSR_W:0]    trial;
  logic              fits;

  // One restoring step a cycle: bring down a dividend bit, compare, subtract
  always_comb begin
    trial    = {rem_r, dvd_r[DVD_W-1]};
    fits     = (trial >= {1'b0, dsr_r});
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      dvd_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? DSR_W'(trial - {1'b0, dsr_r}) : trial[DSR_W-1:0];
      dvd_nxt = {dvd_r[DVD_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DCNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule

@@ rtl/lat_store.sv @@
module lat_store
  import lat_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  store_req_t req,
  output node_rec_t  rd_data,
  output logic       busy
);

  node_rec_t          mem [NODES];
  node_rec_t          rd_data_r;
  logic [NODE_AW-1:0] clr_addr_r, clr_addr_nxt;
  logic               clr_busy_r, clr_busy_nxt;

  // Sweep every entry to zero after reset, one a cycle
  always_comb begin
    clr_addr_nxt = clr_addr_r;
    clr_busy_nxt = clr_busy_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == NODE_AW'(NODES - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      clr_busy_r <= 1'b1;
    end else begin
      clr_addr_r <= clr_addr_nxt;
      clr_busy_r <= clr_busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_busy_r;

endmodule

@@ rtl/lora_airtime_accounting.sv @@
// LoRa time-on-air accounting.
//
// Input channel (in_valid / in_stall): one transmit event per item, carrying
// node number, spreading factor and payload length. The block works out the
// payload symbol count and the packet's time on air in microseconds, adds the
// airtime to the node's saturating total and bumps its saturating transmit
// count. Result channel (out_valid / out_stall): one item per input item with
// this packet's airtime and symbol count and the node's updated totals.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) writes bandwidth,
// coding rate, preamble length, CRC and header mode; cfg_ready is always high.
//
// The block takes no new item until the current one is through: in_stall is
// high whenever the sequencer is not idle. Each item passes the 12-step
// restoring divider that forms the ceiling of the symbol term, then three
// sequencer steps for symbol count, airtime and the read-modify-write.
// After reset the node store is swept to zero, one entry per cycle, with
// in_stall high throughout. A stalled result is held in the output register;
// the block takes the next item meanwhile and waits only at the final step
// until that register frees.
module lora_airtime_accounting
  import lat_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [NODE_W-1:0]    in_node_id,
  input  logic [SF_W-1:0]      in_spreading_factor,
  input  logic [PL_W-1:0]      in_payload_bytes,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [AIR_W-1:0]     out_airtime_us,
  output logic [NSYM_W-1:0]    out_payload_symbols,
  output logic [TOTAL_W-1:0]   out_node_total_us,
  output logic [COUNT_W-1:0]   out_node_tx_count,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  // Configuration registers
  logic [1:0]  cfg_bw_r;
  logic [2:0]  cfg_cr_r;
  logic [15:0] cfg_pre_r;
  logic        cfg_crc_r;
  logic        cfg_ih_r;

  // Sequencer and item registers
  lat_state_t         state_r, state_nxt;
  logic [NODE_AW-1:0] addr_r;
  logic               node_ok_r;
  logic [SF_W-1:0]    sf_r;
  logic [1:0]         bw_r;
  logic [NSYM_W-1:0]  nsym_r, nsym_nxt;
  logic [AIR_W-1:0]   air_r, air_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic [AIR_W-1:0]   out_air_r;
  logic [NSYM_W-1:0]  out_nsym_r;
  logic [TOTAL_W-1:0] out_total_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_load;

  // Accept-time decode
  logic               accept;
  logic               clr_busy;
  logic [SF_W-1:0]    sf_c;
  logic [1:0]         bw_c;
  logic [2:0]         cr_c;
  logic               de_c;
  logic signed [12:0] num_c;
  logic [DSR_W-1:0]   den_c;
  logic [DVD_W-1:0]   dividend_c;
  logic               node_ok_c;

  // Arithmetic for the later steps
  logic [15:0]        term;
  logic [BASE_W-1:0]  base;
  logic [SHIFT_W-1:0] shift;
  logic [WIDE_W-1:0]  air_wide;
  logic [TOTAL_W:0]   total_sum;
  logic [TOTAL_W-1:0] total_new;
  logic [COUNT_W-1:0] count_new;
  logic               out_free;

  div_req_t   div_req;
  div_rsp_t   div_rsp;
  store_req_t st_req;
  node_rec_t  st_rd;

  lat_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  lat_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (st_req),
    .rd_data (st_rd),
    .busy    (clr_busy)
  );

  // Configuration writes; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_bw_r  <= 2'd0;
      cfg_cr_r  <= 3'd1;
      cfg_pre_r <= 16'd8;
      cfg_crc_r <= 1'b1;
      cfg_ih_r  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BANDWIDTH: cfg_bw_r  <= cfg_data[1:0];
        CFG_CODING:    cfg_cr_r  <= cfg_data[2:0];
        CFG_PREAMBLE:  cfg_pre_r <= cfg_data;
        CFG_CRC:       cfg_crc_r <= cfg_data[0];
        CFG_IMPLICIT:  cfg_ih_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_stall = (state_r != ST_IDLE) || clr_busy;
  assign accept   = in_valid && !in_stall;

  // Clamp the item's fields and the settings into their legal ranges
  always_comb begin
    if (in_spreading_factor < SF_MIN) begin
      sf_c = SF_MIN;
    end else if (in_spreading_factor > SF_MAX) begin
      sf_c = SF_MAX;
    end else begin
      sf_c = in_spreading_factor;
    end
    bw_c = (cfg_bw_r > BW_500) ? BW_500 : cfg_bw_r;
    if (cfg_cr_r < CR_MIN) begin
      cr_c = CR_MIN;
    end else if (cfg_cr_r > CR_MAX) begin
      cr_c = CR_MAX;
    end else begin
      cr_c = cfg_cr_r;
    end
    // Low data rate optimisation at 125 kHz for SF11 and SF12
    de_c  = (bw_c == BW_125) && (sf_c >= SF_LDRO);
    num_c = $signed({2'b00, in_payload_bytes, 3'b000}) + 13'sd28
          + (cfg_crc_r ? 13'sd16 : 13'sd0) - $signed({7'd0, sf_c, 2'b00})
          - (cfg_ih_r ? 13'sd20 : 13'sd0);
    den_c = {SF_W'(sf_c - {2'b00, de_c, 1'b0}), 2'b00};
    // Ceiling by adding den - 1 before the division; a non-positive term is 0
    dividend_c = (num_c > 13'sd0) ?
                 DVD_W'(num_c + $signed({7'd0, den_c}) - 13'sd1) : '0;
    node_ok_c  = (17'(in_node_id) < 17'(NODES));
  end

  assign div_req.start    = accept;
  assign div_req.dividend = dividend_c;
  assign div_req.divisor  = den_c;

  // Symbol count, airtime and the node's new totals
  always_comb begin
    term      = 16'(div_rsp.quotient) * 16'({1'b0, cr_c} + 4'd4);
    nsym_nxt  = NSYM_W'(term + 16'd8);
    base      = {cfg_pre_r, 2'b00} + BASE_W'(17) + BASE_W'({nsym_r, 2'b00});
    shift     = sf_r + 4'd1 - {2'b00, bw_r};
    air_wide  = WIDE_W'(base) << shift;
    air_nxt   = (|air_wide[WIDE_W-1:AIR_W]) ? AIR_MAX : air_wide[AIR_W-1:0];
    total_sum = {1'b0, st_rd.total} + (TOTAL_W + 1)'(air_r);
    total_new = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
    count_new = (st_rd.count == COUNT_MAX) ? COUNT_MAX : st_rd.count + 1'b1;
    out_free  = !out_valid_r || !out_stall;
  end

  // Sequencer: next state and store / output strobes
  always_comb begin
    state_nxt      = state_r;
    out_load       = 1'b0;
    st_req.rd_en   = 1'b0;
    st_req.wr_en   = 1'b0;
    st_req.addr    = addr_r;
    st_req.wr_data = '{total: total_new, count: count_new};
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // Fetch the node's record while the divider runs
          st_req.rd_en = 1'b1;
          st_req.addr  = NODE_AW'(in_node_id);
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_SYM;
        end
      end
      ST_SYM: state_nxt = ST_AIR;
      ST_AIR: state_nxt = ST_ACC;
      ST_ACC: begin
        // Hold until the output register can take the result
        if (out_free) begin
          out_load     = 1'b1;
          st_req.wr_en = node_ok_r;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r    <= NODE_AW'(in_node_id);
      node_ok_r <= node_ok_c;
      sf_r      <= sf_c;
      bw_r      <= bw_c;
    end
    if (state_r == ST_SYM) begin
      nsym_r <= nsym_nxt;
    end
    if (state_r == ST_AIR) begin
      air_r <= air_nxt;
    end
    if (out_load) begin
      out_air_r   <= air_r;
      out_nsym_r  <= nsym_r;
      out_total_r <= node_ok_r ? total_new : '0;
      out_count_r <= node_ok_r ? count_new : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_airtime_us      = out_air_r;
  assign out_payload_symbols = out_nsym_r;
  assign out_node_total_us   = out_total_r;
  assign out_node_tx_count   = out_count_r;

endmodule
